// ===== sv/tvi_pkg.sv =====
// ----------------------------------------------------------------------------
// tvi_pkg
// Shared types and constants of the tensor volume interpolator.
// ----------------------------------------------------------------------------
package tvi_pkg;

  localparam int NUM_COMP  = 6;
  localparam int COMP_W    = 3;
  localparam int POS_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 4;
  localparam int CORNERS   = 8;

  // component slots of one tensor
  localparam logic [COMP_W-1:0] COMP_XX = 3'd0;
  localparam logic [COMP_W-1:0] COMP_YY = 3'd1;
  localparam logic [COMP_W-1:0] COMP_ZZ = 3'd2;
  localparam logic [COMP_W-1:0] COMP_XY = 3'd3;
  localparam logic [COMP_W-1:0] COMP_XZ = 3'd4;
  localparam logic [COMP_W-1:0] COMP_YZ = 3'd5;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic {
    MODE_NEAREST = 1'b0,
    MODE_LINEAR  = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERP_MODE = 2'd0,
    REG_SIZE_X      = 2'd1,
    REG_SIZE_Y      = 2'd2,
    REG_SIZE_Z      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_NEAR,
    ST_LIN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  // operand selection of the shared blend unit
  typedef enum logic [2:0] {
    BL_NONE,
    BL_X,
    BL_B0,
    BL_B1,
    BL_Z
  } blend_op_t;

endpackage

// ===== sv/tvi_ifs.sv =====
// ----------------------------------------------------------------------------
// tvi_ifs
// Valid/ready channels of the interpolator: request beats and result beats.
// ----------------------------------------------------------------------------
interface tvi_req_if
  import tvi_pkg::*;
#(
  parameter int DATA_WIDTH = 24,
  parameter int VOX_W      = 5
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic        [VOX_W-1:0]      vox_x;
  logic        [VOX_W-1:0]      vox_y;
  logic        [VOX_W-1:0]      vox_z;
  logic        [COMP_W-1:0]     comp_sel;
  logic signed [DATA_WIDTH-1:0] comp_value;
  logic signed [POS_W-1:0]      pos_x;
  logic signed [POS_W-1:0]      pos_y;
  logic signed [POS_W-1:0]      pos_z;

  modport source (
    output valid, func, vox_x, vox_y, vox_z, comp_sel, comp_value, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, func, vox_x, vox_y, vox_z, comp_sel, comp_value, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface tvi_rsp_if #(
  parameter int DATA_WIDTH = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_xx;
  logic signed [DATA_WIDTH-1:0] out_yy;
  logic signed [DATA_WIDTH-1:0] out_zz;
  logic signed [DATA_WIDTH-1:0] out_xy;
  logic signed [DATA_WIDTH-1:0] out_xz;
  logic signed [DATA_WIDTH-1:0] out_yz;
  logic                         outside;

  modport source (
    output valid, out_xx, out_yy, out_zz, out_xy, out_xz, out_yz, outside,
    input  ready
  );
  modport sink (
    input  valid, out_xx, out_yy, out_zz, out_xy, out_xz, out_yz, outside,
    output ready
  );
endinterface

// ===== sv/tensor_volume_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// tensor_volume_interpolator_unit
// Tensor volume store with nearest and trilinear point queries.
// ----------------------------------------------------------------------------
//
//  channel  dir   beat
//  -------  ----  ------------------------------------------------------------
//  req      in    write one voxel component, or query a Q.FRAC_BITS position
//  rsp      out   six tensor components and the outside flag, one per query
//  cfg_*    in    register write: interp_mode, size_x, size_y, size_z
//
//  A write beat is taken while idle and leaves the channel ready. A query
//  holds the channel busy until its result is registered; the single port of
//  the tensor store serves one read per component or, trilinear, per corner.
//  Reset clears control and registers only; store entries hold garbage
//  until written. A stalled result waits in the output register while the
//  next write beats are still taken; a following query waits at its end.
//
module tensor_volume_interpolator_unit
  import tvi_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int DATA_WIDTH = 24,
  parameter int FRAC_BITS  = 8,
  localparam int SIZE_W    = $clog2(MAX_DIM + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  tvi_req_if.sink              req,
  tvi_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int IW     = $clog2(MAX_DIM);
  localparam int ADDR_W = COMP_W + 3 * IW;
  localparam int DEPTH  = NUM_COMP * (1 << (3 * IW));
  localparam int IDX_A  = POS_W - FRAC_BITS + 2;
  localparam int IDX_W  = (IDX_A > SIZE_W + 2) ? IDX_A : SIZE_W + 2;
  localparam int EXT_W  = POS_W + IDX_W;
  localparam int MAG_W  = ((POS_W > FRAC_BITS) ? POS_W : FRAC_BITS) + 2;

  localparam logic signed [IDX_W-1:0] ZERO_I    = '0;
  localparam logic signed [IDX_W-1:0] ONE_I     = IDX_W'(1);
  localparam logic signed [IDX_W-1:0] MINUS_ONE = '1;
  localparam logic        [MAG_W-1:0] HALF_M    = MAG_W'(1) << (FRAC_BITS - 1);
  localparam logic        [STEP_W-1:0] LIN_END  = STEP_W'(CORNERS);
  localparam logic        [STEP_W-1:0] NEAR_END = STEP_W'(NUM_COMP);
  localparam logic        [COMP_W-1:0] LAST_CMP = COMP_W'(NUM_COMP - 1);

  typedef struct packed {
    logic [IW-1:0]        lo;
    logic [IW-1:0]        hi;
    logic [FRAC_BITS-1:0] w;
    logic                 ok;
  } axis_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return SIZE_W'(1);
    if (s > SIZE_W'(MAX_DIM)) return SIZE_W'(MAX_DIM);
    return s;
  endfunction

  // corner indices, weight and bounds of one axis
  function automatic axis_t axis_setup(input logic signed [POS_W-1:0] p,
                                       input logic [SIZE_W-1:0] s, input mode_t m);
    logic signed [EXT_W-1:0] pe;
    logic signed [EXT_W-1:0] pa;
    logic signed [EXT_W-1:0] fl_e;
    logic        [MAG_W-1:0] mag;
    logic        [MAG_W-1:0] rsum;
    logic        [MAG_W-1:0] rq;
    logic signed [IDX_W-1:0] d;
    logic signed [IDX_W-1:0] i0;
    logic signed [IDX_W-1:0] i1;
    logic signed [IDX_W-1:0] rn;
    axis_t a;
    pe   = {{IDX_W{p[POS_W-1]}}, p};
    fl_e = pe >>> FRAC_BITS;
    i0   = fl_e[IDX_W-1:0];
    i1   = i0 + ONE_I;
    pa   = p[POS_W-1] ? -pe : pe;
    mag  = pa[MAG_W-1:0];
    rsum = mag + HALF_M;
    rq   = rsum >> FRAC_BITS;
    rn   = p[POS_W-1] ? -$signed(IDX_W'(rq)) : $signed(IDX_W'(rq));
    d    = $signed({{(IDX_W - SIZE_W){1'b0}}, eff_size(s)});
    // clamp the edge corners, weight stays as it is
    if (i0 == MINUS_ONE) i0 = ZERO_I;
    if (i1 == d) i1 = d - ONE_I;
    a.w = pe[FRAC_BITS-1:0];
    if (m == MODE_LINEAR) begin
      a.lo = i0[IW-1:0];
      a.hi = i1[IW-1:0];
      a.ok = (i0 >= ZERO_I) && (i1 < d);
    end else begin
      a.lo = rn[IW-1:0];
      a.hi = rn[IW-1:0];
      a.ok = (rn >= ZERO_I) && (rn < d);
    end
    return a;
  endfunction

  // configuration
  mode_t             mode;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  // control
  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [COMP_W-1:0] comp;
  logic              t1_v;
  logic              t2_v;
  logic [COMP_W-1:0] t1_comp;
  logic [COMP_W-1:0] t2_comp;
  logic              acc;
  logic              out_free;
  logic              vox_ok;

  // query datapath
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic signed [POS_W-1:0] pz;
  axis_t ax_c;
  axis_t ay_c;
  axis_t az_c;
  axis_t ax;
  axis_t ay;
  axis_t az;
  logic  inside_c;
  logic  outside_q;

  logic signed [DATA_WIDTH-1:0] lo;
  logic signed [DATA_WIDTH-1:0] a00;
  logic signed [DATA_WIDTH-1:0] a10;
  logic signed [DATA_WIDTH-1:0] a01;
  logic signed [DATA_WIDTH-1:0] a11;
  logic signed [DATA_WIDTH-1:0] b0;
  logic signed [DATA_WIDTH-1:0] b1;
  logic signed [DATA_WIDTH-1:0] res [NUM_COMP];

  // blend unit
  blend_op_t                    bl_op;
  logic signed [DATA_WIDTH-1:0] bl_lo;
  logic signed [DATA_WIDTH-1:0] bl_hi;
  logic        [FRAC_BITS-1:0]  bl_w;
  logic signed [DATA_WIDTH-1:0] bl_y;

  // tensor store
  logic signed [DATA_WIDTH-1:0] store [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata;
  logic        [ADDR_W-1:0]     mem_addr;
  logic                         mem_we;
  logic                         mem_re;

  // result register
  logic                         out_v;
  logic signed [DATA_WIDTH-1:0] out_xx;
  logic signed [DATA_WIDTH-1:0] out_yy;
  logic signed [DATA_WIDTH-1:0] out_zz;
  logic signed [DATA_WIDTH-1:0] out_xy;
  logic signed [DATA_WIDTH-1:0] out_xz;
  logic signed [DATA_WIDTH-1:0] out_yz;
  logic                         out_outside;

  assign acc      = req.valid && req.ready;
  assign out_free = !out_v || rsp.ready;
  assign vox_ok   = (32'(req.vox_x) < 32'(MAX_DIM)) && (32'(req.vox_y) < 32'(MAX_DIM)) &&
                    (32'(req.vox_z) < 32'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_LINEAR;
      size_x <= SIZE_W'(MAX_DIM);
      size_y <= SIZE_W'(MAX_DIM);
      size_z <= SIZE_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INTERP_MODE: mode   <= mode_t'(cfg_data[0]);
        REG_SIZE_X:      size_x <= cfg_data;
        REG_SIZE_Y:      size_y <= cfg_data;
        REG_SIZE_Z:      size_z <= cfg_data;
      endcase
    end
  end

  assign ax_c     = axis_setup(px, size_x, mode);
  assign ay_c     = axis_setup(py, size_y, mode);
  assign az_c     = axis_setup(pz, size_z, mode);
  assign inside_c = ax_c.ok && ay_c.ok && az_c.ok;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (acc && req.func == FUNC_QUERY) state_next = ST_SETUP;
      ST_SETUP: begin
        if (!inside_c) state_next = ST_FINISH;
        else if (mode == MODE_LINEAR) state_next = ST_LIN;
        else state_next = ST_NEAR;
      end
      ST_NEAR:   if (step == NEAR_END) state_next = ST_FINISH;
      ST_LIN:    if (step == LIN_END && comp == LAST_CMP) state_next = ST_TAIL;
      ST_TAIL:   if (t2_v) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake and store port
  always_comb begin
    req.ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {req.comp_sel, IW'(req.vox_z), IW'(req.vox_y), IW'(req.vox_x)};
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        // drop writes to a component slot or voxel that does not exist
        mem_we    = req.valid && req.func == FUNC_WRITE &&
                    req.comp_sel < COMP_W'(NUM_COMP) && vox_ok;
      end
      ST_NEAR: begin
        mem_re   = step < NEAR_END;
        mem_addr = {step[COMP_W-1:0], az.lo, ay.lo, ax.lo};
      end
      ST_LIN: begin
        mem_re   = step < LIN_END;
        mem_addr = {comp, step[2] ? az.hi : az.lo, step[1] ? ay.hi : ay.lo,
                    step[0] ? ax.hi : ax.lo};
      end
      default: ;
    endcase
  end

  // blend schedule: x pairs as the odd corners land, y and z in free slots
  always_comb begin
    bl_op = BL_NONE;
    if (t2_v) begin
      bl_op = BL_Z;
    end else if (t1_v) begin
      bl_op = BL_B1;
    end else if (state == ST_LIN) begin
      case (step) inside
        4'd2, 4'd4, 4'd6, 4'd8: bl_op = BL_X;
        4'd5:                   bl_op = BL_B0;
        default:                bl_op = BL_NONE;
      endcase
    end
  end

  always_comb begin
    bl_lo = lo;
    bl_hi = rdata;
    bl_w  = ax.w;
    case (bl_op)
      BL_B0: begin
        bl_lo = a00;
        bl_hi = a10;
        bl_w  = ay.w;
      end
      BL_B1: begin
        bl_lo = a01;
        bl_hi = a11;
        bl_w  = ay.w;
      end
      BL_Z: begin
        bl_lo = b0;
        bl_hi = b1;
        bl_w  = az.w;
      end
      default: ;
    endcase
  end

  tvi_blend #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_blend (
    .lo (bl_lo),
    .hi (bl_hi),
    .w  (bl_w),
    .y  (bl_y)
  );

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= req.comp_value;
    else if (mem_re) rdata <= store[mem_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      comp  <= '0;
      t1_v  <= 1'b0;
      t2_v  <= 1'b0;
    end else begin
      state <= state_next;
      t1_v  <= state == ST_LIN && step == LIN_END;
      t2_v  <= t1_v;
      case (state)
        ST_SETUP: begin
          step <= '0;
          comp <= '0;
        end
        ST_NEAR: step <= step + STEP_W'(1);
        ST_LIN: begin
          if (step == LIN_END) begin
            step <= '0;
            comp <= comp + COMP_W'(1);
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    t1_comp <= comp;
    t2_comp <= t1_comp;
    if (acc && req.func == FUNC_QUERY) begin
      px <= req.pos_x;
      py <= req.pos_y;
      pz <= req.pos_z;
    end
    if (state == ST_SETUP) begin
      ax        <= ax_c;
      ay        <= ay_c;
      az        <= az_c;
      outside_q <= !inside_c;
    end
    if (state == ST_NEAR && step != '0) begin
      res[COMP_W'(step - STEP_W'(1))] <= rdata;
    end
    if (state == ST_LIN) begin
      case (step) inside
        4'd1, 4'd3, 4'd5, 4'd7: lo <= rdata;
        default: ;
      endcase
    end
    case (bl_op)
      BL_X: begin
        case (step) inside
          4'd2:    a00 <= bl_y;
          4'd4:    a10 <= bl_y;
          4'd6:    a01 <= bl_y;
          default: a11 <= bl_y;
        endcase
      end
      BL_B0:   b0 <= bl_y;
      BL_B1:   b1 <= bl_y;
      BL_Z:    res[t2_comp] <= bl_y;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_xx      <= outside_q ? '0 : res[COMP_XX];
      out_yy      <= outside_q ? '0 : res[COMP_YY];
      out_zz      <= outside_q ? '0 : res[COMP_ZZ];
      out_xy      <= outside_q ? '0 : res[COMP_XY];
      out_xz      <= outside_q ? '0 : res[COMP_XZ];
      out_yz      <= outside_q ? '0 : res[COMP_YZ];
      out_outside <= outside_q;
    end
  end

  assign rsp.valid   = out_v;
  assign rsp.out_xx  = out_xx;
  assign rsp.out_yy  = out_yy;
  assign rsp.out_zz  = out_zz;
  assign rsp.out_xy  = out_xy;
  assign rsp.out_xz  = out_xz;
  assign rsp.out_yz  = out_yz;
  assign rsp.outside = out_outside;

endmodule

// ===== sv/tvi_blend.sv =====
// ----------------------------------------------------------------------------
// tvi_blend
// One linear blend step: lo + round(w * (hi - lo) / 2^FRAC_BITS), ties away
// from zero. The result always lies between lo and hi.
// ----------------------------------------------------------------------------
module tvi_blend #(
  parameter int DATA_WIDTH = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic signed [DATA_WIDTH-1:0] lo,
  input  logic signed [DATA_WIDTH-1:0] hi,
  input  logic        [FRAC_BITS-1:0]  w,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam int DW = DATA_WIDTH + 1;
  localparam int PW = DW + FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [DW-1:0] diff;
  logic        [DW-1:0] mag;
  logic        [PW-1:0] prod;
  logic        [PW-1:0] rnd;
  logic        [DW-1:0] q;
  logic signed [DW:0]   lo_e;
  logic signed [DW:0]   q_e;
  logic signed [DW:0]   sum;

  assign diff = DW'(hi) - DW'(lo);
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign prod = PW'(mag) * PW'(w);
  assign rnd  = prod + HALF;
  assign q    = DW'(rnd >> FRAC_BITS);
  assign lo_e = {{2{lo[DATA_WIDTH-1]}}, lo};
  assign q_e  = $signed({1'b0, q});
  // step toward hi by the rounded magnitude
  assign sum  = diff[DW-1] ? lo_e - q_e : lo_e + q_e;
  assign y    = sum[DATA_WIDTH-1:0];

endmodule

// ===== sv/tvi_checker.sv =====
// ----------------------------------------------------------------------------
// tvi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tvi_checker
  import tvi_pkg::*;
#(
  parameter int DATA_WIDTH = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         req_func,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic signed [DATA_WIDTH-1:0] rsp_xx,
  input logic signed [DATA_WIDTH-1:0] rsp_yy,
  input logic signed [DATA_WIDTH-1:0] rsp_zz,
  input logic signed [DATA_WIDTH-1:0] rsp_xy,
  input logic signed [DATA_WIDTH-1:0] rsp_xz,
  input logic signed [DATA_WIDTH-1:0] rsp_yz,
  input logic                         rsp_outside
);

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_xx, rsp_yy, rsp_zz, rsp_xy, rsp_xz, rsp_yz, rsp_outside}))
    else $error("stalled result beat changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_outside |->
      rsp_xx == '0 && rsp_yy == '0 && rsp_zz == '0 &&
      rsp_xy == '0 && rsp_xz == '0 && rsp_yz == '0)
    else $error("outside result carries nonzero components");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_QUERY |=> !req_ready)
    else $error("request taken while a query is in flight");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_WRITE |=> req_ready)
    else $error("write beat stalled the request channel");

endmodule

bind tensor_volume_interpolator_unit tvi_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_tvi_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_func    (req.func),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_xx      (rsp.out_xx),
  .rsp_yy      (rsp.out_yy),
  .rsp_zz      (rsp.out_zz),
  .rsp_xy      (rsp.out_xy),
  .rsp_xz      (rsp.out_xz),
  .rsp_yz      (rsp.out_yz),
  .rsp_outside (rsp.outside)
);
